@@ sv/lsaa_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the load/store address former and load aligner
// no dependencies; imported by every module of the block

package lsaa_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned RegW  = 4;

	localparam logic [RegW-1:0] RegPc = 4'd15;
	localparam logic [WordW-1:0] PcStoreAdj = 32'd4;

	typedef enum logic {
		CMD_ISSUE  = 1'b0,
		CMD_RETURN = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_WORD_BYTE = 1'b0,
		KIND_HALF_SGN  = 1'b1
	} xfer_kind_t;

	typedef enum logic [1:0] {
		MEM_NONE  = 2'd0,
		MEM_READ  = 2'd1,
		MEM_WRITE = 2'd2
	} mem_op_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2
	} mem_size_t;

	typedef enum logic [1:0] {
		SHIFT_LSL = 2'd0,
		SHIFT_LSR = 2'd1,
		SHIFT_ASR = 2'd2,
		SHIFT_ROR = 2'd3
	} shift_t;

	// bit positions in the instruction word
	localparam int unsigned BitI = 25;
	localparam int unsigned BitP = 24;
	localparam int unsigned BitU = 23;
	localparam int unsigned BitB = 22;
	localparam int unsigned BitW = 21;
	localparam int unsigned BitL = 20;

	typedef struct packed {
		cmd_t             cmd;
		xfer_kind_t       xfer_kind;
		logic [WordW-1:0] instr;
		logic [WordW-1:0] base_value;
		logic [WordW-1:0] offset_value;
		logic [WordW-1:0] source_value;
		logic             carry_in;
		logic [WordW-1:0] mem_data;
	} in_item_t;

	typedef struct packed {
		mem_op_t          mem_op;
		logic [WordW-1:0] mem_addr;
		mem_size_t        mem_size;
		logic [WordW-1:0] write_data;
		logic             wb_enable;
		logic [RegW-1:0]  wb_reg;
		logic [WordW-1:0] wb_value;
		logic             load_valid;
		logic [WordW-1:0] load_value;
		logic [RegW-1:0]  dest_reg;
		logic             flush_pipe;
	} out_item_t;

	// access kept from the last load issue
	typedef struct packed {
		logic [1:0]      addr_low;
		mem_size_t       size;
		logic            sign_ext;
		logic [RegW-1:0] dest;
	} pend_t;

endpackage

@@ sv/lsaa_addr.sv @@
`timescale 1ns / 1ps
// issue path: offset forming, indexing, memory request and base writeback
// depends on lsaa_pkg

module lsaa_addr (
	input  lsaa_pkg::in_item_t  item,
	output lsaa_pkg::out_item_t res,
	output lsaa_pkg::pend_t     pend_nxt,
	output logic                pend_we
);
	import lsaa_pkg::*;

	logic [WordW-1:0] ins;
	logic [WordW-1:0] rm;
	logic [4:0]       amt;
	shift_t           stype;
	logic [WordW-1:0] shifted;
	logic [WordW-1:0] off;
	logic [WordW-1:0] off_dir;
	logic [WordW-1:0] sum;
	logic [WordW-1:0] addr;
	logic             is_load;
	logic             sgn;
	mem_size_t        size;
	logic [RegW-1:0]  rn;
	logic [RegW-1:0]  rd;
	logic [2*WordW-1:0] rot_src;

	assign ins     = item.instr;
	assign rm      = item.offset_value;
	assign amt     = ins[11:7];
	assign stype   = shift_t'(ins[6:5]);
	assign is_load = ins[BitL];
	assign rn      = ins[19:16];
	assign rd      = ins[15:12];
	assign rot_src = {rm, rm};

	// register offset shifter, amount zero has the special encodings
	always_comb begin
		case (stype)
			SHIFT_LSL: shifted = rm << amt;
			SHIFT_LSR: shifted = (amt == 5'd0) ? '0 : (rm >> amt);
			SHIFT_ASR: shifted = (amt == 5'd0) ? {WordW{rm[WordW-1]}}
			                                   : WordW'($signed(rm) >>> amt);
			SHIFT_ROR: shifted = (amt == 5'd0) ? {item.carry_in, rm[WordW-1:1]}
			                                   : rot_src[amt +: WordW];
			default:   shifted = rm;
		endcase
	end

	always_comb begin
		sgn = 1'b0;
		if (item.xfer_kind == KIND_WORD_BYTE) begin
			off  = ins[BitI] ? shifted : {20'd0, ins[11:0]};
			size = ins[BitB] ? SIZE_BYTE : SIZE_WORD;
		end else begin
			off = ins[BitB] ? {24'd0, ins[11:8], ins[3:0]} : rm;
			if (is_load) begin
				size = ins[5] ? SIZE_HALF : SIZE_BYTE;
				sgn  = ins[6];
			end else begin
				size = SIZE_HALF;
			end
		end
	end

	assign off_dir = ins[BitU] ? off : (WordW'(0) - off);
	assign sum     = item.base_value + off_dir;
	assign addr    = ins[BitP] ? sum : item.base_value;

	always_comb begin
		res          = '0;
		res.mem_op   = is_load ? MEM_READ : MEM_WRITE;
		res.mem_addr = addr;
		res.mem_size = size;
		if (!is_load)
			res.write_data = item.source_value + ((rd == RegPc) ? PcStoreAdj : '0);
		if ((ins[BitW] || !ins[BitP]) && (!is_load || rn != rd)) begin
			res.wb_enable = 1'b1;
			res.wb_reg    = rn;
			res.wb_value  = sum;
		end
	end

	assign pend_we           = is_load;
	assign pend_nxt.addr_low = addr[1:0];
	assign pend_nxt.size     = size;
	assign pend_nxt.sign_ext = sgn;
	assign pend_nxt.dest     = rd;

endmodule

@@ sv/lsaa_align.sv @@
`timescale 1ns / 1ps
// return path: rotation and sign extension of raw load data
// depends on lsaa_pkg

module lsaa_align (
	input  lsaa_pkg::pend_t         pend,
	input  logic [lsaa_pkg::WordW-1:0] raw,
	output lsaa_pkg::out_item_t     res
);
	import lsaa_pkg::*;

	logic [WordW-1:0] val;
	logic [15:0]      hw;

	assign hw = raw[15:0];

	always_comb begin
		case (pend.size)
			SIZE_WORD: begin
				case (pend.addr_low)
					2'd0:    val = raw;
					2'd1:    val = {raw[7:0], raw[31:8]};
					2'd2:    val = {raw[15:0], raw[31:16]};
					default: val = {raw[23:0], raw[31:24]};
				endcase
			end
			SIZE_HALF: begin
				if (pend.addr_low[0])
					val = pend.sign_ext ? {{24{hw[15]}}, hw[15:8]}
					                    : {hw[7:0], 16'd0, hw[15:8]};
				else
					val = pend.sign_ext ? {{16{hw[15]}}, hw} : {16'd0, hw};
			end
			default: val = pend.sign_ext ? {{24{raw[7]}}, raw[7:0]} : {24'd0, raw[7:0]};
		endcase
	end

	always_comb begin
		res            = '0;
		res.load_valid = 1'b1;
		res.load_value = val;
		res.dest_reg   = pend.dest;
		res.flush_pipe = (pend.dest == RegPc);
	end

endmodule

@@ sv/load_store_addr_align_unit.sv @@
`timescale 1ns / 1ps
// top level of the load/store address former and load aligner
// depends on lsaa_pkg, lsaa_addr, lsaa_align

// usage
// - req channel: one item per transfer, either an issue (instruction with
//   base, offset and store register values) or a load return (raw data)
// - rsp channel: exactly one result per request, in request order
// - an issue gives the memory request and base writeback; a load issue
//   also records its access so the next return can be aligned
// - a return gives the rotated or sign extended register value
// - a request accepted into the input register moves on into the result
//   register and shows on rsp from there
// - throughput: one request per cycle while rsp is not stalled; the path
//   between the two registers is one barrel shift, a negate, one 32-bit add and the output muxes
// - a return accepted right after a load issue sees that load's access:
//   the kept access is updated as the issue moves into the result register
// - rsp stall holds the result register; the input register still takes
//   one more request, after which req_stall rises
// - reset clears the valid flags and the kept access (unsigned byte,
//   address offset 0, destination R0)

module load_store_addr_align_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  lsaa_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output lsaa_pkg::out_item_t rsp
);
	import lsaa_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t rsp_q;
	logic      rsp_valid_q;
	pend_t     pend_q;

	out_item_t issue_res;
	out_item_t ret_res;
	pend_t     pend_nxt;
	logic      pend_we;
	logic      advance;
	logic      load_s1;

	// result register is free or being drained this cycle
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign load_s1   = req_valid && !req_stall;

	lsaa_addr u_addr (
		.item     (item_s1),
		.res      (issue_res),
		.pend_nxt (pend_nxt),
		.pend_we  (pend_we)
	);

	lsaa_align u_align (
		.pend (pend_q),
		.raw  (item_s1.mem_data),
		.res  (ret_res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1)
			item_s1 <= req;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			rsp_q <= (item_s1.cmd == CMD_RETURN) ? ret_res : issue_res;
	end

	// kept load access, written as a load issue completes its pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (advance && valid_s1 && item_s1.cmd == CMD_ISSUE && pend_we) begin
			pend_q <= pend_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sv/lsaa_checker.sv @@
`timescale 1ns / 1ps
// port level checks for load_store_addr_align_unit, attached by bind
// depends on lsaa_pkg

module lsaa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input lsaa_pkg::out_item_t rsp
);
	import lsaa_pkg::*;

	// held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// a load value never comes with a memory request or writeback
	a_ret_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.load_valid |-> rsp.mem_op == MEM_NONE && !rsp.wb_enable)
		else $error("load result mixed with issue fields");

	// refill only for a load into the program counter
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.flush_pipe |-> rsp.load_valid && rsp.dest_reg == RegPc)
		else $error("flush without load to pc");

	// an issue result always makes an access
	a_issue_op: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.load_valid |-> rsp.mem_op == MEM_READ || rsp.mem_op == MEM_WRITE)
		else $error("issue result without memory access");

	// a load request writes no store data
	a_load_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.mem_op == MEM_READ |-> rsp.write_data == '0)
		else $error("store data on a read");

endmodule

bind load_store_addr_align_unit lsaa_checker u_lsaa_checker (.*);
